FILE: rtl/texture_mip_layout_calc_unit_macros.svh
// Assertion macros for the texture mip layout calculator.
// Included by the top level; no other dependencies.
`ifndef TEXTURE_MIP_LAYOUT_CALC_UNIT_MACROS_SVH
`define TEXTURE_MIP_LAYOUT_CALC_UNIT_MACROS_SVH

// Same-cycle implication, checked while reset is low.
`define TMLC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tmlc: same-cycle check failed");

// Next-cycle implication, checked while reset is low.
`define TMLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tmlc: next-cycle check failed");

`endif

FILE: rtl/tmlc_pkg.sv
// Shared constants, types and format decode for the texture mip layout calculator.
// No dependencies.
package tmlc_pkg;

   localparam int MIP_COUNT  = 15;
   localparam int MAX_EXTENT = 16384;

   localparam int LEVEL_W  = 4;
   localparam int FORMAT_W = 7;
   localparam int EXTENT_W = 15;
   localparam int OFFSET_W = 33;
   localparam int PITCH_W  = 19;
   localparam int ROWS_W   = 15;
   localparam int SIZE_W   = 33;

   localparam int BYTES_W = 5;
   localparam int BLOCK_W = 4;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(MIP_COUNT - 1);

   localparam int FMT_TABLE_SIZE = 79;
   localparam logic [FORMAT_W-1:0] FMT_COMP_FIRST = 7'd31;
   localparam logic [FORMAT_W-1:0] FMT_COMP_LAST  = 7'd72;
   localparam logic [FORMAT_W-1:0] FMT_ASTC_FIRST = 7'd45;

   // Block counts come from multiplying by 2^DIV_SHIFT / divisor, rounded up.
   // That is exact for any numerator below 2^15 and divisors up to 12.
   localparam int DIV_SHIFT = 19;
   localparam int RECIP_W   = 18;
   localparam logic [RECIP_W-1:0] RECIP_4  = RECIP_W'((2**DIV_SHIFT + 3) / 4);
   localparam logic [RECIP_W-1:0] RECIP_5  = RECIP_W'((2**DIV_SHIFT + 4) / 5);
   localparam logic [RECIP_W-1:0] RECIP_6  = RECIP_W'((2**DIV_SHIFT + 5) / 6);
   localparam logic [RECIP_W-1:0] RECIP_8  = RECIP_W'((2**DIV_SHIFT + 7) / 8);
   localparam logic [RECIP_W-1:0] RECIP_10 = RECIP_W'((2**DIV_SHIFT + 9) / 10);
   localparam logic [RECIP_W-1:0] RECIP_12 = RECIP_W'((2**DIV_SHIFT + 11) / 12);

   localparam logic [7:0] FMT_BITS [FMT_TABLE_SIZE] = '{
      8'd0,
      8'd128, 8'd128, 8'd128,
      8'd64, 8'd64, 8'd64,
      8'd96, 8'd96, 8'd96,
      8'd64, 8'd64, 8'd64,
      8'd32, 8'd32, 8'd32, 8'd32, 8'd32, 8'd32,
      8'd16, 8'd16, 8'd16,
      8'd32, 8'd32, 8'd32, 8'd32,
      8'd16, 8'd8,
      8'd32, 8'd32, 8'd16,
      8'd8, 8'd8, 8'd16, 8'd16, 8'd16, 8'd16, 8'd8, 8'd8,
      8'd16, 8'd16, 8'd16, 8'd16, 8'd16, 8'd16,
      8'd16, 8'd16, 8'd16, 8'd16, 8'd16, 8'd16, 8'd16,
      8'd16, 8'd16, 8'd16, 8'd16, 8'd16, 8'd16, 8'd16,
      8'd16, 8'd16, 8'd16, 8'd16, 8'd16, 8'd16, 8'd16,
      8'd16, 8'd16, 8'd16, 8'd16, 8'd16, 8'd16, 8'd16,
      8'd32, 8'd32, 8'd32,
      8'd64, 8'd32, 8'd32
   };

   localparam int ASTC_KINDS = 14;
   localparam logic [BLOCK_W-1:0] ASTC_BW [ASTC_KINDS] = '{
      4'd4, 4'd5, 4'd5, 4'd6, 4'd6, 4'd8, 4'd8, 4'd8, 4'd10, 4'd10, 4'd10, 4'd10, 4'd12, 4'd12
   };
   localparam logic [BLOCK_W-1:0] ASTC_BH [ASTC_KINDS] = '{
      4'd4, 4'd4, 4'd5, 4'd5, 4'd6, 4'd5, 4'd6, 4'd8, 4'd5, 4'd6, 4'd8, 4'd10, 4'd10, 4'd12
   };
   localparam logic [RECIP_W-1:0] ASTC_RW [ASTC_KINDS] = '{
      RECIP_4, RECIP_5, RECIP_5, RECIP_6, RECIP_6, RECIP_8, RECIP_8,
      RECIP_8, RECIP_10, RECIP_10, RECIP_10, RECIP_10, RECIP_12, RECIP_12
   };
   localparam logic [RECIP_W-1:0] ASTC_RH [ASTC_KINDS] = '{
      RECIP_4, RECIP_4, RECIP_5, RECIP_5, RECIP_6, RECIP_5, RECIP_6,
      RECIP_8, RECIP_5, RECIP_6, RECIP_8, RECIP_10, RECIP_10, RECIP_12
   };

   typedef struct packed {
      logic [BYTES_W-1:0] bytes;
      logic               comp;
      logic [BLOCK_W-1:0] bw_m1;
      logic [BLOCK_W-1:0] bh_m1;
      logic [RECIP_W-1:0] recip_w;
      logic [RECIP_W-1:0] recip_h;
   } fmt_info_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;
      logic div;
      logic acc;
      logic pitch;
      logic size;
      logic out_load;
   } tmlc_cmd_type;

   function automatic fmt_info_type fmt_decode(input logic [FORMAT_W-1:0] code);
      fmt_info_type       info;
      logic [FORMAT_W-1:0] rel;
      logic [3:0]         kind;
      info.bytes   = '0;
      info.comp    = 1'b0;
      info.bw_m1   = 4'd3;
      info.bh_m1   = 4'd3;
      info.recip_w = RECIP_4;
      info.recip_h = RECIP_4;
      rel  = code - FMT_ASTC_FIRST;
      kind = rel[4:1];
      if (32'(code) < FMT_TABLE_SIZE) begin
         info.bytes = FMT_BITS[code][7:3];
         info.comp  = (code >= FMT_COMP_FIRST) && (code <= FMT_COMP_LAST);
         if (info.comp && (code >= FMT_ASTC_FIRST)) begin
            info.bw_m1   = ASTC_BW[kind] - 4'd1;
            info.bh_m1   = ASTC_BH[kind] - 4'd1;
            info.recip_w = ASTC_RW[kind];
            info.recip_h = ASTC_RH[kind];
         end
      end
      return info;
   endfunction

endpackage

FILE: rtl/tmlc_ifs.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on tmlc_pkg for field widths.
interface tmlc_req_if import tmlc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [LEVEL_W-1:0]  mip_level;
   logic [FORMAT_W-1:0] format_code;
   logic [EXTENT_W-1:0] base_width;
   logic [EXTENT_W-1:0] base_height;

   modport source (output valid, mip_level, format_code, base_width, base_height,
                   input ready);
   modport sink (input valid, mip_level, format_code, base_width, base_height,
                 output ready);
endinterface

interface tmlc_rsp_if import tmlc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OFFSET_W-1:0] byte_offset;
   logic [PITCH_W-1:0]  row_pitch;
   logic [ROWS_W-1:0]   row_count;
   logic [SIZE_W-1:0]   level_size;

   modport source (output valid, byte_offset, row_pitch, row_count, level_size,
                   input ready);
   modport sink (input valid, byte_offset, row_pitch, row_count, level_size,
                 output ready);
endinterface

FILE: rtl/tmlc_ctrl.sv
// Sequencer for the mip chain walk: three steps per level, then the result hand-off.
// Depends on tmlc_pkg.
module tmlc_ctrl import tmlc_pkg::*; #(
   parameter logic [LEVEL_W-1:0] LAST_LEVEL = LEVEL_MAX
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [LEVEL_W-1:0] req_mip_level,
   output logic               req_ready,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output tmlc_cmd_type       cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_PITCH,
      ST_SIZE,
      ST_EMIT
   } state_type;

   state_type          state_ff, state_in;
   logic [LEVEL_W-1:0] target_ff, target_in;
   logic [LEVEL_W-1:0] count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      target_in    = target_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load  = 1'b1;
               target_in = (req_mip_level > LAST_LEVEL) ? LAST_LEVEL : req_mip_level;
               count_in  = '0;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div  = 1'b1;
            cmd.acc  = (count_ff != '0);
            state_in = ST_PITCH;
         end
         ST_PITCH: begin
            cmd.pitch = 1'b1;
            state_in  = ST_SIZE;
         end
         ST_SIZE: begin
            cmd.size = 1'b1;
            if (count_ff == target_ff) begin
               state_in = ST_EMIT;
            end else begin
               count_in = count_ff + 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         target_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         target_ff    <= target_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/tmlc_dp.sv
// Datapath: extent halving, block rounding, pitch and size products, offset sum.
// Depends on tmlc_pkg; driven by tmlc_ctrl commands.
module tmlc_dp import tmlc_pkg::*; #(
   parameter int EXTENT_LIMIT = MAX_EXTENT
) (
   input  logic                clock,
   input  tmlc_cmd_type        cmd,
   input  logic [FORMAT_W-1:0] req_format_code,
   input  logic [EXTENT_W-1:0] req_base_width,
   input  logic [EXTENT_W-1:0] req_base_height,
   output logic [OFFSET_W-1:0] rsp_byte_offset,
   output logic [PITCH_W-1:0]  rsp_row_pitch,
   output logic [ROWS_W-1:0]   rsp_row_count,
   output logic [SIZE_W-1:0]   rsp_level_size
);

   localparam int NUM_W  = EXTENT_W + 1;
   localparam int PROD_W = NUM_W + RECIP_W;

   function automatic logic [EXTENT_W-1:0] clamp_extent(input logic [EXTENT_W-1:0] v);
      logic [EXTENT_W-1:0] e;
      e = v;
      if (e == '0) begin
         e = EXTENT_W'(1);
      end
      if (32'(e) > EXTENT_LIMIT) begin
         e = EXTENT_W'(EXTENT_LIMIT);
      end
      return e;
   endfunction

   function automatic logic [EXTENT_W-1:0] halve(input logic [EXTENT_W-1:0] v);
      return (v[EXTENT_W-1:1] == '0) ? EXTENT_W'(1) : (v >> 1);
   endfunction

   fmt_info_type        fmt_ff;
   logic [EXTENT_W-1:0] width_ff, height_ff;
   logic [EXTENT_W-1:0] cols_ff, rows_ff;
   logic [PITCH_W-1:0]  pitch_ff;
   logic [SIZE_W-1:0]   size_ff;
   logic [OFFSET_W-1:0] offset_ff;

   logic [OFFSET_W-1:0] out_offset_ff;
   logic [PITCH_W-1:0]  out_pitch_ff;
   logic [ROWS_W-1:0]   out_rows_ff;
   logic [SIZE_W-1:0]   out_size_ff;

   logic [NUM_W-1:0]    num_w, num_h;
   logic [PROD_W-1:0]   prod_w, prod_h;
   logic [EXTENT_W-1:0] cols_in, rows_in;
   logic [19:0]         pitch_prod;
   logic [33:0]         size_prod;

   // Rounded-up block counts by reciprocal multiply.
   assign num_w   = NUM_W'(width_ff) + NUM_W'(fmt_ff.bw_m1);
   assign num_h   = NUM_W'(height_ff) + NUM_W'(fmt_ff.bh_m1);
   assign prod_w  = PROD_W'(num_w) * PROD_W'(fmt_ff.recip_w);
   assign prod_h  = PROD_W'(num_h) * PROD_W'(fmt_ff.recip_h);
   assign cols_in = fmt_ff.comp ? prod_w[DIV_SHIFT +: EXTENT_W] : width_ff;
   assign rows_in = fmt_ff.comp ? prod_h[DIV_SHIFT +: EXTENT_W] : height_ff;

   assign pitch_prod = 20'(cols_ff) * 20'(fmt_ff.bytes);
   assign size_prod  = 34'(pitch_ff) * 34'(rows_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         fmt_ff    <= fmt_decode(req_format_code);
         width_ff  <= clamp_extent(req_base_width);
         height_ff <= clamp_extent(req_base_height);
         offset_ff <= '0;
      end
      if (cmd.div) begin
         cols_ff   <= cols_in;
         rows_ff   <= rows_in;
         width_ff  <= halve(width_ff);
         height_ff <= halve(height_ff);
         if (cmd.acc) begin
            offset_ff <= offset_ff + size_ff;
         end
      end
      if (cmd.pitch) begin
         pitch_ff <= pitch_prod[PITCH_W-1:0];
      end
      if (cmd.size) begin
         size_ff <= size_prod[SIZE_W-1:0];
      end
      if (cmd.out_load) begin
         out_offset_ff <= offset_ff;
         out_pitch_ff  <= pitch_ff;
         out_rows_ff   <= rows_ff;
         out_size_ff   <= size_ff;
      end
   end

   assign rsp_byte_offset = out_offset_ff;
   assign rsp_row_pitch   = out_pitch_ff;
   assign rsp_row_count   = out_rows_ff;
   assign rsp_level_size  = out_size_ff;

endmodule

FILE: rtl/texture_mip_layout_calc_unit.sv
// Each accepted item walks the mip levels from zero up to the requested one, capped
// at MIP_LEVELS - 1, going through the block-rounding, pitch and size multiply steps
// per level; no new item is taken until its result is handed to the output register.
// A waiting result sits in an output register, so a new item can start while it waits.
// Reset is synchronous and active high; it returns the sequencer to idle and drops the
// response valid; datapath payload registers are not reset.
`include "texture_mip_layout_calc_unit_macros.svh"

module texture_mip_layout_calc_unit import tmlc_pkg::*; #(
   parameter int MIP_LEVELS   = MIP_COUNT,
   parameter int EXTENT_LIMIT = MAX_EXTENT
) (
   input  logic        clock,
   input  logic        reset,
   tmlc_req_if.sink    req_bus,
   tmlc_rsp_if.source  rsp_bus
);

   // Commands from the sequencer to the datapath. Each accepted item is loaded
   // into the datapath, then every mip level from zero up to the requested one
   // (capped at MIP_LEVELS - 1) takes three steps: rounding the extents to block
   // counts (and adding the previous level's size to the running offset), forming
   // the row pitch, and forming the level size. After the last level the result
   // is copied into the output register once that register is free.
   tmlc_cmd_type cmd;

   tmlc_ctrl #(
      .LAST_LEVEL (LEVEL_W'(MIP_LEVELS - 1))
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_bus.valid),
      .req_mip_level (req_bus.mip_level),
      .req_ready     (req_bus.ready),
      .rsp_ready     (rsp_bus.ready),
      .rsp_valid     (rsp_bus.valid),
      .cmd           (cmd)
   );

   tmlc_dp #(
      .EXTENT_LIMIT (EXTENT_LIMIT)
   ) u_dp (
      .clock           (clock),
      .cmd             (cmd),
      .req_format_code (req_bus.format_code),
      .req_base_width  (req_bus.base_width),
      .req_base_height (req_bus.base_height),
      .rsp_byte_offset (rsp_bus.byte_offset),
      .rsp_row_pitch   (rsp_bus.row_pitch),
      .rsp_row_count   (rsp_bus.row_count),
      .rsp_level_size  (rsp_bus.level_size)
   );

   // The sequencer leaves idle as soon as an item is taken.
   `TMLC_ASSERT_NEXT(a_busy_after_accept, clock, reset,
                     req_bus.valid && req_bus.ready, !req_bus.ready)
   // A result loaded into the output register is offered in the next cycle.
   `TMLC_ASSERT_NEXT(a_load_shows_valid, clock, reset, cmd.out_load, rsp_bus.valid)
   // The output register is never overwritten while its item is still waiting.
   `TMLC_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.out_load,
                    !rsp_bus.valid || rsp_bus.ready)
   // Only one datapath step is commanded in any cycle.
   `TMLC_ASSERT_NOW(a_one_step, clock, reset, 1'b1,
                    $onehot0({cmd.load, cmd.div, cmd.pitch, cmd.size, cmd.out_load}))

endmodule
